>>> design/trrem_pkg.sv
// Shared types, constants and function codes of the two-ring rumble envelope mixer.
package trrem_pkg;

    localparam int SLOTS     = 32;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = 6;
    localparam int FRAC_BITS = 7;
    localparam int LEVEL_W   = 8;
    localparam int WORD_W    = 16;
    localparam int DIV_CNT_W = $clog2(WORD_W + 1);

    localparam logic [2:0] FUNC_TICK      = 3'd0;
    localparam logic [2:0] FUNC_ADD_PULSE = 3'd1;
    localparam logic [2:0] FUNC_ADD_LARGE = 3'd2;
    localparam logic [2:0] FUNC_ADD_RAMP  = 3'd3;
    localparam logic [2:0] FUNC_CLEAR     = 3'd4;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [WORD_W-1:0]  delay;
        logic [WORD_W-1:0]  remaining;
        logic [WORD_W-1:0]  step;
        logic [WORD_W-1:0]  acc;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic load;
        logic tick_rd;
        logic search;
        logic add_rd;
        logic add_wr;
        logic clear;
        logic res_load;
        logic res_acc;
    } cmd_t;

    typedef struct packed {
        logic idx_last;
        logic add_ready;
        logic add_drop;
    } sts_t;

endpackage

>>> design/trrem_ram.sv
// Generic single-write, single-read RAM with registered read data.
module trrem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/trrem_ctrl.sv
// Controller state machine that sequences ticks, adds, clears and result hand-off.
module trrem_ctrl
    import trrem_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_func,
    output logic       m_valid,
    input  logic       m_ready,
    output cmd_t       cmd,
    input  sts_t       sts
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_TICK      = 3'd1;
    localparam logic [2:0] ST_TICK_END  = 3'd2;
    localparam logic [2:0] ST_ADD_RUN   = 3'd3;
    localparam logic [2:0] ST_ADD_READ  = 3'd4;
    localparam logic [2:0] ST_ADD_WRITE = 3'd5;
    localparam logic [2:0] ST_RESULT    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       acc_reg, acc_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        acc_next     = acc_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    acc_next = 1'b0;
                    unique case (s_func) inside
                        FUNC_TICK: state_next = ST_TICK;
                        FUNC_ADD_PULSE, FUNC_ADD_LARGE, FUNC_ADD_RAMP: state_next = ST_ADD_RUN;
                        FUNC_CLEAR: begin
                            cmd.clear  = 1'b1;
                            state_next = ST_RESULT;
                        end
                        default: state_next = ST_RESULT;
                    endcase
                end
            end
            ST_TICK: begin
                cmd.tick_rd = 1'b1;
                if (sts.idx_last) begin
                    state_next = ST_TICK_END;
                end
            end
            ST_TICK_END: begin
                state_next = ST_RESULT;
            end
            ST_ADD_RUN: begin
                cmd.search = 1'b1;
                if (sts.add_ready) begin
                    state_next = sts.add_drop ? ST_RESULT : ST_ADD_READ;
                end
            end
            ST_ADD_READ: begin
                cmd.add_rd = 1'b1;
                state_next = ST_ADD_WRITE;
            end
            ST_ADD_WRITE: begin
                cmd.add_wr = 1'b1;
                acc_next   = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                cmd.res_acc = acc_reg;
                if (!m_valid_reg || m_ready) begin
                    cmd.res_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            acc_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            acc_reg     <= acc_next;
        end
    end

    assign m_valid = m_valid_reg;

    // A new result is never loaded over one that is still waiting to be taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !cmd.res_load)
        else $error("result overwritten before its transaction");

    // Input transactions are only taken in the idle state.
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (state_reg == ST_IDLE))
        else $error("item loaded outside idle");

    // A slot write of an add is always preceded by its read.
    a_write_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.add_wr |-> $past(cmd.add_rd))
        else $error("add write without preceding read");

endmodule

>>> design/trrem_datapath.sv
// Datapath: slot memories, busy flags, fill counters, serial divider and level maxima.
module trrem_datapath
    import trrem_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [2:0]         s_func,
    input  logic [15:0]        s_duration,
    input  logic [15:0]        s_start_delay,
    input  logic [7:0]         s_amplitude,
    input  logic [7:0]         s_ramp_start,
    input  logic [7:0]         s_ramp_end,
    input  logic               s_ring_select,
    output logic [7:0]         m_actuator0_level,
    output logic [7:0]         m_actuator1_level,
    output logic               m_accepted,
    output logic [CNT_W-1:0]   m_fill_count
);

    logic [2:0]          func_reg;
    logic [WORD_W-1:0]   dur_reg;
    logic [WORD_W-1:0]   dly_reg;
    logic [LEVEL_W-1:0]  amp_reg;
    logic [LEVEL_W-1:0]  rs_reg;
    logic                sel_reg;

    logic [SLOTS-1:0]    busy_reg  [2];
    logic [SLOTS-1:0]    valid_reg [2];
    logic [CNT_W-1:0]    cnt_reg   [2];
    logic [LEVEL_W-1:0]  max_reg   [2];

    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_d_reg;
    logic                pend_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic                found_reg;
    logic                full_reg;

    logic [WORD_W-1:0]    drem_reg;
    logic [WORD_W-1:0]    dq_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic                 neg_reg;

    logic [7:0]          m_lvl0_reg, m_lvl1_reg;
    logic                m_acc_reg;
    logic [CNT_W-1:0]    m_fill_reg;

    logic                add_ring;
    logic [SLOT_W-1:0]   rdata [2];
    logic [SLOT_W-1:0]   wdata [2];
    logic                we    [2];
    logic [IDX_W-1:0]    waddr [2];
    logic [IDX_W-1:0]    raddr;
    logic                re;

    slot_t               ent   [2];
    slot_t               upd   [2];
    logic                frees [2];
    logic                contrib [2];
    logic [WORD_W-1:0]   sum   [2];
    slot_t               add_ent;
    slot_t               add_old;
    logic [WORD_W-1:0]   step_q;
    logic [WORD_W:0]     div_trial;
    logic [8:0]          diff;
    logic [7:0]          mag;
    logic                is_busy [2];

    assign add_ring = (func_reg != FUNC_ADD_PULSE);
    assign raddr    = cmd.add_rd ? free_idx_reg : idx_reg;
    assign re       = cmd.tick_rd || cmd.add_rd;

    // Magnitude of the ramp span; the quotient sign is applied afterwards.
    assign diff = {1'b0, s_ramp_end} - {1'b0, s_ramp_start};
    assign mag  = diff[8] ? 8'(-diff) : diff[7:0];

    assign div_trial = {drem_reg, dq_reg[WORD_W-1]};
    assign step_q    = neg_reg ? WORD_W'(-dq_reg) : dq_reg;

    always_comb begin
        for (int r = 0; r < 2; r++) begin
            is_busy[r] = busy_reg[r][idx_d_reg];
            ent[r]     = valid_reg[r][idx_d_reg] ? slot_t'(rdata[r]) : '0;
            upd[r]     = ent[r];
            frees[r]   = 1'b0;
            contrib[r] = 1'b0;
            sum[r]     = ent[r].acc + ent[r].step;
            if (is_busy[r]) begin
                if (ent[r].delay != '0) begin
                    upd[r].delay = ent[r].delay - 1'b1;
                end else begin
                    upd[r].remaining = ent[r].remaining - 1'b1;
                    frees[r]         = (ent[r].remaining == WORD_W'(1));
                    contrib[r]       = 1'b1;
                    if (ent[r].step != '0) begin
                        upd[r].acc   = sum[r];
                        upd[r].level = sum[r][FRAC_BITS +: LEVEL_W];
                    end
                end
            end
        end
    end

    always_comb begin
        add_old = valid_reg[add_ring][free_idx_reg] ? slot_t'(rdata[add_ring]) : '0;
        add_ent           = add_old;
        add_ent.delay     = dly_reg;
        add_ent.remaining = dur_reg;
        if (func_reg == FUNC_ADD_RAMP) begin
            add_ent.step = step_q;
            add_ent.acc  = {1'b0, rs_reg, 7'b0};
        end else begin
            add_ent.level = (func_reg == FUNC_ADD_PULSE) ? LEVEL_W'(1) : amp_reg;
            add_ent.step  = '0;
            add_ent.acc   = '0;
        end
    end

    always_comb begin
        for (int r = 0; r < 2; r++) begin
            if (cmd.add_wr && (add_ring == r[0])) begin
                we[r]    = 1'b1;
                waddr[r] = free_idx_reg;
                wdata[r] = add_ent;
            end else begin
                we[r]    = pend_reg && is_busy[r];
                waddr[r] = idx_d_reg;
                wdata[r] = upd[r];
            end
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_ring
        trrem_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_ram (
            .aclk  (aclk),
            .we    (we[g]),
            .waddr (waddr[g]),
            .wdata (wdata[g]),
            .re    (re),
            .raddr (raddr),
            .rdata (rdata[g])
        );
    end

    // Item latch, index, search and divider.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_func;
            dur_reg  <= s_duration;
            dly_reg  <= s_start_delay;
            amp_reg  <= s_amplitude;
            rs_reg   <= s_ramp_start;
            sel_reg  <= s_ring_select;
            drem_reg <= '0;
            dq_reg   <= {1'b0, mag, 7'b0};
            neg_reg  <= diff[8];
            idx_d_reg <= '0;
        end else begin
            if (dcnt_reg != '0) begin
                if (div_trial >= {1'b0, dur_reg}) begin
                    drem_reg <= WORD_W'(div_trial - {1'b0, dur_reg});
                    dq_reg   <= {dq_reg[WORD_W-2:0], 1'b1};
                end else begin
                    drem_reg <= div_trial[WORD_W-1:0];
                    dq_reg   <= {dq_reg[WORD_W-2:0], 1'b0};
                end
            end
            idx_d_reg <= idx_reg;
        end
        if (cmd.search && !found_reg && !full_reg && !busy_reg[add_ring][idx_reg]) begin
            free_idx_reg <= idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            full_reg  <= 1'b0;
            dcnt_reg  <= '0;
        end else begin
            pend_reg <= cmd.tick_rd;
            if (cmd.load) begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
                full_reg  <= 1'b0;
                dcnt_reg  <= DIV_CNT_W'(WORD_W);
            end else begin
                if (dcnt_reg != '0) begin
                    dcnt_reg <= dcnt_reg - 1'b1;
                end
                if (cmd.tick_rd) begin
                    idx_reg <= idx_reg + 1'b1;
                end else if (cmd.search && !found_reg && !full_reg) begin
                    if (!busy_reg[add_ring][idx_reg]) begin
                        found_reg <= 1'b1;
                    end else if (idx_reg == IDX_W'(SLOTS - 1)) begin
                        full_reg <= 1'b1;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Busy and written flags, fill counts and running maxima.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 2; r++) begin
                busy_reg[r]  <= '0;
                valid_reg[r] <= '0;
                cnt_reg[r]   <= '0;
                max_reg[r]   <= '0;
            end
        end else if (cmd.clear) begin
            for (int r = 0; r < 2; r++) begin
                busy_reg[r]  <= '0;
                valid_reg[r] <= '0;
                cnt_reg[r]   <= '0;
                max_reg[r]   <= '0;
            end
        end else begin
            for (int r = 0; r < 2; r++) begin
                if (cmd.load) begin
                    max_reg[r] <= '0;
                end else if (pend_reg && contrib[r] && (upd[r].level > max_reg[r])) begin
                    max_reg[r] <= upd[r].level;
                end
                if (pend_reg && frees[r]) begin
                    busy_reg[r][idx_d_reg] <= 1'b0;
                    cnt_reg[r]             <= cnt_reg[r] - 1'b1;
                end
                if (cmd.add_wr && (add_ring == r[0])) begin
                    busy_reg[r][free_idx_reg]  <= 1'b1;
                    valid_reg[r][free_idx_reg] <= 1'b1;
                    cnt_reg[r]                 <= cnt_reg[r] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            m_lvl0_reg <= (func_reg == FUNC_TICK) ? max_reg[0] : '0;
            m_lvl1_reg <= (func_reg == FUNC_TICK) ? max_reg[1] : '0;
            m_acc_reg  <= cmd.res_acc;
            m_fill_reg <= cnt_reg[sel_reg];
        end
    end

    assign sts.idx_last  = (idx_reg == IDX_W'(SLOTS - 1));
    assign sts.add_ready = (found_reg || full_reg) && (dcnt_reg == '0);
    assign sts.add_drop  = full_reg || (dur_reg == '0);

    assign m_actuator0_level = m_lvl0_reg;
    assign m_actuator1_level = m_lvl1_reg;
    assign m_accepted        = m_acc_reg;
    assign m_fill_count      = m_fill_reg;

    // A ring never reports more busy slots than it has.
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg[0] <= CNT_W'(SLOTS)) && (cnt_reg[1] <= CNT_W'(SLOTS)))
        else $error("fill count beyond slot count");

    // A busy slot has always been written since the last clear.
    a_busy_written: assert property (@(posedge aclk) disable iff (!aresetn)
        ((busy_reg[0] & ~valid_reg[0]) == '0) && ((busy_reg[1] & ~valid_reg[1]) == '0))
        else $error("busy slot without stored contents");

    // The free-slot search ends either with a slot or with a full ring, never both.
    a_search_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        !(found_reg && full_reg))
        else $error("search both found and full");

endmodule

>>> design/two_ring_rumble_envelope_mixer_top.sv
// Top level of the two-ring rumble envelope mixer.
//
// Each transaction is one command: a tick, an add to one of the two 32-slot rings, or a clear,
// and it returns exactly one result. A tick walks both rings in parallel, one slot per cycle
// through the slot memories. An add runs a 16-step serial divide for the ramp slope alongside a
// one-slot-per-cycle search for the lowest free slot, then, unless the ring is full or the
// duration is zero, a read and write of that slot. The next command is taken once the current
// one has finished, while its result may still wait at the output.
module two_ring_rumble_envelope_mixer_top
    import trrem_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [2:0]   s_func,
    input  logic [15:0]  s_duration,
    input  logic [15:0]  s_start_delay,
    input  logic [7:0]   s_amplitude,
    input  logic [7:0]   s_ramp_start,
    input  logic [7:0]   s_ramp_end,
    input  logic         s_ring_select,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [7:0]   m_actuator0_level,
    output logic [7:0]   m_actuator1_level,
    output logic         m_accepted,
    output logic [5:0]   m_fill_count
);

    cmd_t cmd;
    sts_t sts;

    trrem_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    trrem_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_func            (s_func),
        .s_duration        (s_duration),
        .s_start_delay     (s_start_delay),
        .s_amplitude       (s_amplitude),
        .s_ramp_start      (s_ramp_start),
        .s_ramp_end        (s_ramp_end),
        .s_ring_select     (s_ring_select),
        .m_actuator0_level (m_actuator0_level),
        .m_actuator1_level (m_actuator1_level),
        .m_accepted        (m_accepted),
        .m_fill_count      (m_fill_count)
    );

endmodule
